// File: rtl/core/sc2a_pkg.sv
// ----------------------------------------------------------------------------
// sc2a_pkg
// Shared types, constants and key tables for the scancode-to-ASCII FIFO unit.
// ----------------------------------------------------------------------------
package sc2a_pkg;

    // Character FIFO geometry; holds at most FIFO_DEPTH - 1 characters
    localparam int unsigned FIFO_DEPTH = 256;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FIFO_DEPTH - 1);

    localparam int unsigned CHAR_W   = 7;
    localparam int unsigned CODE_W   = 8;
    localparam int unsigned NUM_KEYS = 59;

    // Request kinds
    localparam logic REQ_SCAN = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Set-1 codes with special handling
    localparam logic [CODE_W-1:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [CODE_W-1:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [CODE_W-1:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [CODE_W-1:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam logic [CODE_W-1:0] SC_CAPS_MAKE    = 8'h3A;

    localparam logic [CHAR_W-1:0] PLAIN_MAP [NUM_KEYS] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
        7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
    };

    localparam logic [CHAR_W-1:0] SHIFTED_MAP [NUM_KEYS] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
        7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
    };

    // Character for a code; 0 for codes past the table
    function automatic logic [CHAR_W-1:0] key_char(
        input logic [CODE_W-1:0] code,
        input logic              shifted
    );
        logic [CHAR_W-1:0] ch;
        ch = '0;
        if (code < CODE_W'(NUM_KEYS))
        begin
            ch = shifted ? SHIFTED_MAP[code[5:0]] : PLAIN_MAP[code[5:0]];
        end
        return ch;
    endfunction

    // Control carried alongside the RAM read
    typedef struct packed {
        logic pop;
        logic empty;
        logic ovf;
    } s1_ctrl_t;

endpackage

// File: rtl/core/sc2a_req_if.sv
// ----------------------------------------------------------------------------
// sc2a_req_if
// Request channel: keyboard scancode or character read.
// ----------------------------------------------------------------------------
interface sc2a_req_if;
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [sc2a_pkg::CODE_W-1:0] scan_code;

    modport source (output valid, output req_type, output scan_code, input ready);
    modport sink   (input valid, input req_type, input scan_code, output ready);
endinterface

// File: rtl/core/sc2a_rsp_if.sv
// ----------------------------------------------------------------------------
// sc2a_rsp_if
// Result channel: popped character and FIFO status.
// ----------------------------------------------------------------------------
interface sc2a_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        char_valid;
    logic [sc2a_pkg::CHAR_W-1:0] char_out;
    logic                        fifo_empty;
    logic                        overflow;

    modport source (
        output valid, output char_valid, output char_out,
        output fifo_empty, output overflow, input ready
    );
    modport sink (
        input valid, input char_valid, input char_out,
        input fifo_empty, input overflow, output ready
    );
endinterface

// File: rtl/core/sc2a_ram.sv
// ----------------------------------------------------------------------------
// sc2a_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sc2a_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/core/scancode_to_ascii_fifo_unit.sv
// ----------------------------------------------------------------------------
// scancode_to_ascii_fifo_unit
// Set-1 scancode decoder feeding a character FIFO, with a read request port.
// ----------------------------------------------------------------------------
// Each request is either a keyboard scancode or a read of one character, and
// each gives exactly one result. Scancodes update the shift / caps-lock flags
// or map through the plain or shifted key table; a non-zero character is
// pushed into a FIFO of FIFO_DEPTH entries (at most FIFO_DEPTH - 1 held). A
// character arriving at a full FIFO is dropped and the result flags overflow.
// A read of an empty FIFO returns char_valid = 0 and char_out = 0. One request
// is taken every cycle while the result side does not stall; each result passes
// through the registered read port of the character RAM and then the output
// register. The character RAM needs no clearing after reset: only entries
// that were written are ever read, so requests are taken right away.
// ----------------------------------------------------------------------------
module scancode_to_ascii_fifo_unit (
    input  logic       clk,
    input  logic       rst_n,
    sc2a_req_if.sink   req,
    sc2a_rsp_if.source rsp
);

    localparam int unsigned PW = sc2a_pkg::PTR_W;
    localparam int unsigned CW = sc2a_pkg::CHAR_W;

    // Decode flags and FIFO pointers
    logic          shift_held_reg, shift_held_next;
    logic          caps_on_reg, caps_on_next;
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;

    // Stage 1: RAM read in flight
    logic                 s1_valid_reg;
    sc2a_pkg::s1_ctrl_t   s1_ctrl_reg, s1_ctrl_next;

    // Output register
    logic          out_valid_reg;
    logic          out_char_valid_reg;
    logic [CW-1:0] out_char_reg;
    logic          out_empty_reg;
    logic          out_ovf_reg;

    logic          accept;
    logic          s1_adv;
    logic          push;
    logic          pop;
    logic          ovf_drop;
    logic          was_empty;
    logic [PW-1:0] wr_ptr_inc;
    logic [PW-1:0] rd_ptr_inc;
    logic [CW-1:0] key_ch;
    logic [CW-1:0] ram_rdata;

    // ------------------------------------------------------------------
    // Handshake: output register frees when empty or drained; stage 1
    // moves into it, and a new request enters whenever stage 1 frees.
    // ------------------------------------------------------------------
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_adv;
    assign accept    = req.valid && req.ready;

    assign wr_ptr_inc = (wr_ptr_reg == sc2a_pkg::LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == sc2a_pkg::LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
    assign was_empty  = (wr_ptr_reg == rd_ptr_reg);
    assign key_ch     = sc2a_pkg::key_char(req.scan_code, shift_held_reg || caps_on_reg);

    // ------------------------------------------------------------------
    // Request decode. Shift make and caps codes sit inside the key table range,
    // so they are checked first.
    // ------------------------------------------------------------------
    always_comb
    begin
        shift_held_next = shift_held_reg;
        caps_on_next    = caps_on_reg;
        push            = 1'b0;
        pop             = 1'b0;
        ovf_drop        = 1'b0;
        if (accept)
        begin
            priority if (req.req_type == sc2a_pkg::REQ_READ)
            begin
                pop = !was_empty;
            end
            else if (req.scan_code == sc2a_pkg::SC_LSHIFT_MAKE ||
                     req.scan_code == sc2a_pkg::SC_RSHIFT_MAKE)
            begin
                shift_held_next = 1'b1;
            end
            else if (req.scan_code == sc2a_pkg::SC_LSHIFT_BREAK ||
                     req.scan_code == sc2a_pkg::SC_RSHIFT_BREAK)
            begin
                shift_held_next = 1'b0;
            end
            else if (req.scan_code == sc2a_pkg::SC_CAPS_MAKE)
            begin
                caps_on_next = !caps_on_reg;
            end
            else if (key_ch != '0)
            begin
                // full: one free slot is always kept
                if (wr_ptr_inc == rd_ptr_reg)
                begin
                    ovf_drop = 1'b1;
                end
                else
                begin
                    push = 1'b1;
                end
            end
            else
            begin
                // unmapped code: no effect
                push = 1'b0;
            end
        end
    end

    assign wr_ptr_next  = push ? wr_ptr_inc : wr_ptr_reg;
    assign rd_ptr_next  = pop  ? rd_ptr_inc : rd_ptr_reg;
    assign s1_ctrl_next = '{pop: pop, empty: (wr_ptr_next == rd_ptr_next), ovf: ovf_drop};

    // ------------------------------------------------------------------
    // Character store. A pop reads an entry written in an earlier cycle,
    // and a push and a pop never come from the same request, so no
    // forwarding is needed. Read data stays put while stage 1 stalls
    // because reads are issued only on accepted requests.
    // ------------------------------------------------------------------
    sc2a_ram #(
        .WIDTH (sc2a_pkg::CHAR_W),
        .DEPTH (sc2a_pkg::FIFO_DEPTH)
    ) u_char_ram (
        .clk     (clk),
        .wr_en   (push),
        .wr_addr (wr_ptr_reg),
        .wr_data (key_ch),
        .rd_en   (pop),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_held_reg <= 1'b0;
            caps_on_reg    <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            shift_held_reg <= shift_held_next;
            caps_on_reg    <= caps_on_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            if (req.ready)
            begin
                s1_valid_reg <= accept;
            end
            if (!out_valid_reg || rsp.ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctrl_reg <= s1_ctrl_next;
        end
        if (s1_adv)
        begin
            out_char_valid_reg <= s1_ctrl_reg.pop;
            out_char_reg       <= s1_ctrl_reg.pop ? ram_rdata : '0;
            out_empty_reg      <= s1_ctrl_reg.empty;
            out_ovf_reg        <= s1_ctrl_reg.ovf;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.char_valid = out_char_valid_reg;
    assign rsp.char_out   = out_char_reg;
    assign rsp.fifo_empty = out_empty_reg;
    assign rsp.overflow   = out_ovf_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && pop))
        else $error("push and pop in the same cycle");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("pop from an empty FIFO");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (wr_ptr_next != rd_ptr_reg))
        else $error("push into a full FIFO");

    a_rdata_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv && s1_ctrl_reg.pop) |=> $stable(ram_rdata))
        else $error("RAM read data changed while stage 1 stalled");

    a_ovf_excl: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |-> !(s1_ctrl_reg.pop && s1_ctrl_reg.ovf))
        else $error("read result flagged overflow");

endmodule

// File: tb/char_fifo_tracker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// char_fifo_tracker
// Watches both channels, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
// Every accepted request is decoded against a private copy of the shift and
// caps-lock flags and of the character FIFO. The expected result is queued,
// and each accepted result is checked against the oldest one.
// ----------------------------------------------------------------------------
module char_fifo_tracker (
    input  logic        clk,
    input  logic        rst_n,
    sc2a_req_if         req,
    sc2a_rsp_if         rsp,
    output int unsigned outstanding,
    output int unsigned fail_count
);

    localparam int unsigned CHAR_W     = sc2a_pkg::CHAR_W;
    localparam int unsigned CODE_W     = sc2a_pkg::CODE_W;
    localparam int unsigned PTR_W      = sc2a_pkg::PTR_W;
    localparam int unsigned FIFO_DEPTH = sc2a_pkg::FIFO_DEPTH;
    localparam int unsigned NUM_KEYS   = sc2a_pkg::NUM_KEYS;

    typedef struct packed {
        logic              char_valid;
        logic [CHAR_W-1:0] char_out;
        logic              fifo_empty;
        logic              overflow;
    } key_result_t;

    localparam logic [CHAR_W-1:0] unshifted_chars [NUM_KEYS] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00
    };

    localparam logic [CHAR_W-1:0] shifted_chars [NUM_KEYS] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00
    };

    logic              shift_held;
    logic              caps_on;
    logic [CHAR_W-1:0] char_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr;
    logic [PTR_W-1:0]  rd_ptr;
    key_result_t       expected_q [$];
    int unsigned       errors;

    function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Applies one request to the shadow state and returns its result
    function automatic key_result_t decode_event(
        input logic              kind,
        input logic [CODE_W-1:0] code
    );
        key_result_t       r;
        logic [CHAR_W-1:0] ch;
        logic [PTR_W-1:0]  nxt;
        r = '0;
        if (kind == sc2a_pkg::REQ_READ)
        begin
            if (wr_ptr != rd_ptr)
            begin
                r.char_valid = 1'b1;
                r.char_out   = char_mem[rd_ptr];
                rd_ptr       = step_ptr(rd_ptr);
            end
        end
        else if (code == sc2a_pkg::SC_LSHIFT_MAKE || code == sc2a_pkg::SC_RSHIFT_MAKE)
        begin
            shift_held = 1'b1;
        end
        else if (code == sc2a_pkg::SC_LSHIFT_BREAK || code == sc2a_pkg::SC_RSHIFT_BREAK)
        begin
            shift_held = 1'b0;
        end
        else if (code == sc2a_pkg::SC_CAPS_MAKE)
        begin
            caps_on = !caps_on;
        end
        else if (code < CODE_W'(NUM_KEYS))
        begin
            ch = (shift_held || caps_on) ? shifted_chars[code[5:0]]
                                         : unshifted_chars[code[5:0]];
            if (ch != '0)
            begin
                nxt = step_ptr(wr_ptr);
                // one slot stays free; a full FIFO drops the character
                if (nxt == rd_ptr)
                begin
                    r.overflow = 1'b1;
                end
                else
                begin
                    char_mem[wr_ptr] = ch;
                    wr_ptr           = nxt;
                end
            end
        end
        r.fifo_empty = (wr_ptr == rd_ptr);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        key_result_t want;
        key_result_t seen;
        if (!rst_n)
        begin
            shift_held = 1'b0;
            caps_on    = 1'b0;
            wr_ptr     = '0;
            rd_ptr     = '0;
            errors     = 0;
            expected_q.delete();
            outstanding <= 0;
            fail_count  <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                expected_q.push_back(decode_event(req.req_type, req.scan_code));
            end
            if (rsp.valid && rsp.ready)
            begin
                seen = '{rsp.char_valid, rsp.char_out, rsp.fifo_empty, rsp.overflow};
                if (expected_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("%0t: result with no request pending:", $time);
                        $display("    valid=%0b char=%h empty=%0b ovf=%0b",
                                 seen.char_valid, seen.char_out, seen.fifo_empty,
                                 seen.overflow);
                    end
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (seen !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("%0t: mismatch", $time);
                            $display("    expected valid=%0b char=%h empty=%0b ovf=%0b",
                                     want.char_valid, want.char_out, want.fifo_empty,
                                     want.overflow);
                            $display("    got      valid=%0b char=%h empty=%0b ovf=%0b",
                                     seen.char_valid, seen.char_out, seen.fifo_empty,
                                     seen.overflow);
                        end
                    end
                end
            end
            outstanding <= expected_q.size();
            fail_count  <= errors;
        end
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the scancode-to-ASCII FIFO unit.
// ----------------------------------------------------------------------------
// A directed opener walks the shift, caps-lock and ignored codes and reads
// an empty FIFO. Random phases follow: mixed traffic, a typing burst that
// fills the character FIFO past full, a read-heavy drain that empties it,
// and a final mixed phase with no idling. Both sides idle in short random
// bursts, and once the result side holds off long enough to stall requests.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned CLK_PERIOD   = 8;
    localparam int unsigned RESET_CYCLES = 7;
    localparam int unsigned HOLD_CYCLES  = 64;      // long result-side stall
    localparam int unsigned DRAIN_CYCLES = 8;       // settle time after the last result
    localparam int unsigned CYCLE_LIMIT  = 100000;
    localparam int unsigned CODE_W       = sc2a_pkg::CODE_W;
    localparam int unsigned NUM_KEYS     = sc2a_pkg::NUM_KEYS;

    logic        clk;
    logic        rst_n;
    int unsigned outstanding;
    int unsigned fail_count;
    int unsigned cycles;
    bit          idle_enable;
    bit          hold_off;

    sc2a_req_if req_ch ();
    sc2a_rsp_if rsp_ch ();

    scancode_to_ascii_fifo_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    char_fifo_tracker tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Watchdog: a stuck handshake or a missing result ends here
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: random short stalls, plus one long hold-off on request
    initial
    begin
        int unsigned k;
        bit          held;
        held = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off && !held)
            begin
                held = 1'b1;
                rsp_ch.ready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++)
                begin
                    @(posedge clk);
                end
                rsp_ch.ready <= 1'b1;
            end
            else if (idle_enable && $urandom_range(0, 4) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                rsp_ch.ready <= 1'b1;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Offers one request and returns at the edge that accepts it, then
    // sometimes leaves a short gap. valid stays high between back-to-back
    // requests so it is never dropped and raised in the same step.
    task automatic issue(input logic kind, input logic [CODE_W-1:0] code);
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= kind;
        req_ch.scan_code <= code;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        if (idle_enable && $urandom_range(0, 4) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // scan_pct: share of scancode requests (rest are reads).
    // key_pct: share of scancodes drawn from the key table range; the rest
    // split into shift make, shift break, caps lock and any byte at all.
    task automatic run_phase(
        input int unsigned count,
        input int unsigned scan_pct,
        input int unsigned key_pct
    );
        int unsigned       n;
        int unsigned       pick;
        int unsigned       rest;
        logic [CODE_W-1:0] code;
        rest = 100 - key_pct;
        for (n = 0; n < count; n++)
        begin
            code = CODE_W'($urandom_range(0, 255));
            if ($urandom_range(1, 100) > scan_pct)
            begin
                // a read ignores the code, so it carries random bits
                issue(sc2a_pkg::REQ_READ, code);
            end
            else
            begin
                pick = $urandom_range(1, 100);
                if (pick <= key_pct)
                    code = CODE_W'($urandom_range(0, NUM_KEYS - 1));
                else if (pick <= key_pct + rest * 3 / 10)
                    code = $urandom_range(0, 1) ? sc2a_pkg::SC_LSHIFT_MAKE
                                                : sc2a_pkg::SC_RSHIFT_MAKE;
                else if (pick <= key_pct + rest * 6 / 10)
                    code = $urandom_range(0, 1) ? sc2a_pkg::SC_LSHIFT_BREAK
                                                : sc2a_pkg::SC_RSHIFT_BREAK;
                else if (pick <= key_pct + rest * 7 / 10)
                    code = sc2a_pkg::SC_CAPS_MAKE;
                issue(sc2a_pkg::REQ_SCAN, code);
            end
        end
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= sc2a_pkg::REQ_SCAN;
        req_ch.scan_code <= '0;
        idle_enable      <= 1'b1;
        hold_off         <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed opener ----
        issue(sc2a_pkg::REQ_READ, 8'hFF);           // read of an empty FIFO
        issue(sc2a_pkg::REQ_SCAN, 8'h00);           // in table, maps to nothing
        issue(sc2a_pkg::REQ_SCAN, 8'h02);           // '1'
        issue(sc2a_pkg::REQ_SCAN, sc2a_pkg::SC_LSHIFT_MAKE);
        issue(sc2a_pkg::REQ_SCAN, 8'h02);           // '!' with left shift
        issue(sc2a_pkg::REQ_SCAN, sc2a_pkg::SC_LSHIFT_BREAK);
        issue(sc2a_pkg::REQ_SCAN, sc2a_pkg::SC_RSHIFT_MAKE);
        issue(sc2a_pkg::REQ_SCAN, 8'h1E);           // 'A' with right shift
        issue(sc2a_pkg::REQ_SCAN, sc2a_pkg::SC_RSHIFT_BREAK);
        issue(sc2a_pkg::REQ_SCAN, sc2a_pkg::SC_CAPS_MAKE);  // caps on
        issue(sc2a_pkg::REQ_SCAN, 8'h0C);           // caps shifts symbols too: '_'
        issue(sc2a_pkg::REQ_SCAN, sc2a_pkg::SC_LSHIFT_MAKE);
        issue(sc2a_pkg::REQ_SCAN, 8'h11);           // shift and caps together: still 'W'
        issue(sc2a_pkg::REQ_SCAN, sc2a_pkg::SC_LSHIFT_BREAK);
        issue(sc2a_pkg::REQ_SCAN, sc2a_pkg::SC_CAPS_MAKE);  // caps off
        issue(sc2a_pkg::REQ_SCAN, 8'h39);           // space, last mapped key
        issue(sc2a_pkg::REQ_SCAN, 8'h3A + 8'h01);   // first code past the table
        issue(sc2a_pkg::REQ_SCAN, 8'hFF);           // ignored
        issue(sc2a_pkg::REQ_SCAN, 8'h80);           // break of an ordinary key: ignored
        issue(sc2a_pkg::REQ_SCAN, 8'h38);           // unmapped key below caps lock
        repeat (7) issue(sc2a_pkg::REQ_READ, 8'h00);    // drain six, then one empty

        // ---- random phases ----
        hold_off <= 1'b1;               // long stall while requests keep coming
        run_phase(400, 50, 75);
        run_phase(500, 95, 90);         // typing burst: overruns the FIFO
        run_phase(450, 15, 75);         // drain, then many empty reads

        // last stretch with no idling on either side
        idle_enable <= 1'b0;
        run_phase(400, 50, 75);
        req_ch.valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/sc2a_pkg.sv
rtl/core/sc2a_req_if.sv
rtl/core/sc2a_rsp_if.sv
rtl/core/sc2a_ram.sv
rtl/core/scancode_to_ascii_fifo_unit.sv
tb/char_fifo_tracker.sv
tb/testbench.sv
